### rtl/crq_pkg.sv
// Shared constants, types and helpers of the consecutive range query engine.
package crq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int VALUE_LIMIT  = 1024;

  localparam int VAL_W  = 10;
  localparam int POS_W  = 11;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int VIDX_W = $clog2(VALUE_LIMIT);
  localparam int LV_W   = $clog2(LEVELS + 1);
  localparam int TBL_D  = LEVELS * MAX_ELEMENTS;
  localparam int TBL_AW = $clog2(TBL_D);

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LV_W-1:0]  lv_t;

  // Table address of level lv, zero-based position p.
  function automatic logic [TBL_AW-1:0] tbl_addr(input lv_t lv, input logic [IDX_W-1:0] p);
    int a;
    a = int'(lv) * MAX_ELEMENTS + int'(p);
    return a[TBL_AW-1:0];
  endfunction

  // Index of the highest set bit; zero for zero.
  function automatic lv_t floor_log2(input pos_t x);
    lv_t r;
    r = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (x[i]) r = lv_t'(i);
    end
    return r;
  endfunction

endpackage

### rtl/consecutive_range_query_engine.sv
// Top level: sequencer, stores and output register of the range query engine.
// Append: reads the seen flag, walks the window head past each dropped element,
//   then merges one table level at a time through the one table read port.
// Query: one memory read at a time. Clear: sweep of all 1024 seen flags.
// Reset starts the same sweep of the seen flags; no request is taken during it.
// Results wait in an output register while the next request is accepted.
module consecutive_range_query_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [crq_pkg::CMD_W-1:0] command,
  input  crq_pkg::val_t           value,
  input  crq_pkg::pos_t           left_pos,
  input  crq_pkg::pos_t           right_pos,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    is_consecutive,
  output logic                    range_error
);
  import crq_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SEEN   = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_DROP   = 4'd4;
  localparam logic [3:0] S_LVL    = 4'd5;
  localparam logic [3:0] S_MERGE  = 4'd6;
  localparam logic [3:0] S_Q_WS   = 4'd7;
  localparam logic [3:0] S_Q_A    = 4'd8;
  localparam logic [3:0] S_Q_B    = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]        state;
  logic [VIDX_W-1:0] clr_idx;
  pos_t              count, head, pos, lft, rgt;
  val_t              val, cur_min, cur_max;
  lv_t               lv, k;
  logic              flag;
  logic              res_consec, res_err;

  // store ports
  logic              seen_we, seen_wd, seen_rd;
  logic [VIDX_W-1:0] seen_wa, seen_ra;
  logic              app_we;
  logic [IDX_W-1:0]  st_ra;
  val_t              st_rd;
  logic [IDX_W-1:0]  ws_ra;
  pos_t              ws_rd;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_wa, tbl_ra;
  val_t              tbl_wmin, tbl_wmax, min_rd, max_rd;
  val_t              mm_lo, mm_hi;

  logic accept;
  pos_t q_len;
  lv_t  q_k;
  logic q_bad;
  logic [POS_W:0] q_p;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign q_len = right_pos - left_pos + pos_t'(1);
  assign q_k   = floor_log2(q_len);
  assign q_bad = (left_pos == '0) || (left_pos > right_pos) || (right_pos > count)
                 || (int'(q_k) >= LEVELS);
  // zero-based address of the block that opens at lft
  assign q_p   = {1'b0, lft} + ((POS_W+1)'(1) << k) - (POS_W+1)'(2);

  crq_minmax u_mm (
    .a_min(cur_min), .a_max(cur_max), .b_min(min_rd), .b_max(max_rd),
    .lo(mm_lo), .hi(mm_hi)
  );

  // seen flags: sweep, drop, or mark the new value
  always_comb begin
    seen_we = 1'b0;
    seen_wa = val[VIDX_W-1:0];
    seen_wd = 1'b0;
    case (state)
      S_CLR: begin
        seen_we = 1'b1;
        seen_wa = clr_idx;
      end
      S_DROP: begin
        seen_we = 1'b1;
        seen_wa = st_rd[VIDX_W-1:0];
      end
      S_WALK: begin
        if (!(flag && head <= count)) begin
          seen_we = 1'b1;
          seen_wd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign seen_ra = value[VIDX_W-1:0];
  assign app_we  = (state == S_WALK) && !(flag && head <= count);
  assign st_ra   = IDX_W'(head - pos_t'(1));
  assign ws_ra   = IDX_W'(right_pos - pos_t'(1));

  always_comb begin
    tbl_we   = 1'b0;
    tbl_wa   = tbl_addr(lv, IDX_W'(pos - pos_t'(1)));
    tbl_wmin = mm_lo;
    tbl_wmax = mm_hi;
    tbl_ra   = tbl_addr(lv - lv_t'(1), IDX_W'(pos - (pos_t'(1) << (lv - lv_t'(1))) - pos_t'(1)));
    if (app_we) begin
      tbl_we   = 1'b1;
      tbl_wa   = tbl_addr('0, IDX_W'(pos - pos_t'(1)));
      tbl_wmin = val;
      tbl_wmax = val;
    end else if (state == S_MERGE) begin
      tbl_we = 1'b1;
    end
    case (state)
      S_Q_WS: tbl_ra = tbl_addr(k, q_p[IDX_W-1:0]);
      S_Q_A:  tbl_ra = tbl_addr(k, IDX_W'(rgt - pos_t'(1)));
      default: ;
    endcase
  end

  crq_ram #(.DEPTH(VALUE_LIMIT), .WIDTH(1), .AW(VIDX_W)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(seen_wd),
    .raddr(seen_ra), .rdata(seen_rd)
  );
  crq_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(VAL_W), .AW(IDX_W)) u_store (
    .clk(clk), .we(app_we), .waddr(IDX_W'(pos - pos_t'(1))), .wdata(val),
    .raddr(st_ra), .rdata(st_rd)
  );
  crq_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(POS_W), .AW(IDX_W)) u_wstart (
    .clk(clk), .we(app_we), .waddr(IDX_W'(pos - pos_t'(1))), .wdata(head),
    .raddr(ws_ra), .rdata(ws_rd)
  );
  crq_ram #(.DEPTH(TBL_D), .WIDTH(VAL_W), .AW(TBL_AW)) u_min (
    .clk(clk), .we(tbl_we), .waddr(tbl_wa), .wdata(tbl_wmin),
    .raddr(tbl_ra), .rdata(min_rd)
  );
  crq_ram #(.DEPTH(TBL_D), .WIDTH(VAL_W), .AW(TBL_AW)) u_max (
    .clk(clk), .we(tbl_we), .waddr(tbl_wa), .wdata(tbl_wmax),
    .raddr(tbl_ra), .rdata(max_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      count     <= '0;
      head      <= pos_t'(1);
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded this cycle
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + VIDX_W'(1);
          if (int'(clr_idx) == VALUE_LIMIT - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (command)
              CMD_APPEND: begin
                val <= value;
                pos <= count + pos_t'(1);
                if (int'(count) >= MAX_ELEMENTS || int'(value) >= VALUE_LIMIT) begin
                  res_consec <= 1'b0;
                  res_err    <= 1'b1;
                  state      <= S_EMIT;
                end else begin
                  state <= S_SEEN;
                end
              end
              CMD_QUERY: begin
                lft <= left_pos;
                rgt <= right_pos;
                k   <= q_k;
                if (q_bad) begin
                  res_consec <= 1'b0;
                  res_err    <= 1'b1;
                  state      <= S_EMIT;
                end else begin
                  state <= S_Q_WS;
                end
              end
              CMD_CLEAR: begin
                count   <= '0;
                head    <= pos_t'(1);
                clr_idx <= '0;
                state   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_SEEN: begin
          flag  <= seen_rd;
          state <= S_WALK;
        end
        S_WALK: begin
          if (flag && head <= count) begin
            state <= S_DROP;
          end else begin
            cur_min <= val;
            cur_max <= val;
            lv      <= lv_t'(1);
            state   <= S_LVL;
          end
        end
        S_DROP: begin
          // drop the oldest window element
          if (st_rd == val) flag <= 1'b0;
          head  <= head + pos_t'(1);
          state <= S_WALK;
        end
        S_LVL: begin
          if (int'(lv) < LEVELS && (pos >> lv) != '0) begin
            state <= S_MERGE;
          end else begin
            count <= pos;
            state <= S_IDLE;
          end
        end
        S_MERGE: begin
          cur_min <= mm_lo;
          cur_max <= mm_hi;
          lv      <= lv + lv_t'(1);
          state   <= S_LVL;
        end
        S_Q_WS: begin
          if (ws_rd > lft) begin
            res_consec <= 1'b0;
            res_err    <= 1'b0;
            state      <= S_EMIT;
          end else begin
            state <= S_Q_A;
          end
        end
        S_Q_A: begin
          cur_min <= min_rd;
          cur_max <= max_rd;
          state   <= S_Q_B;
        end
        S_Q_B: begin
          res_consec <= (pos_t'(mm_hi - mm_lo) == (rgt - lft));
          res_err    <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            is_consecutive <= res_consec;
            range_error    <= res_err;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= count + pos_t'(1)) else $error("window head beyond end");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_ELEMENTS) else $error("element count overflow");
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_consecutive && range_error)) else $error("error with match");
  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !in_ready) else $error("ready during sweep");

endmodule

### rtl/crq_ram.sv
// Generic single-write, single-read memory with registered read data.
module crq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/crq_minmax.sv
// Shared compare unit: merge two min/max pairs.
module crq_minmax (
  input  crq_pkg::val_t a_min,
  input  crq_pkg::val_t a_max,
  input  crq_pkg::val_t b_min,
  input  crq_pkg::val_t b_max,
  output crq_pkg::val_t lo,
  output crq_pkg::val_t hi
);
  import crq_pkg::*;

  assign lo = (a_min < b_min) ? a_min : b_min;
  assign hi = (a_max > b_max) ? a_max : b_max;
endmodule
